// ===== hw/rtl/sqofs_pkg.sv =====
// Shared types and constants for the oldest-first scheduling queue.
// No dependencies; used by the interfaces, the slot cell and the top level.
`timescale 1ns / 1ps
package sqofs_pkg;

  localparam int CMD_W = 2;
  localparam int ID_W  = 16;
  localparam int TAG_W = 9;
  localparam int STS_W = 2;
  localparam int OCC_W = 7;
  localparam int IW_W  = 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;

  // -1 as a 9-bit tag: operand ready
  localparam logic [TAG_W-1:0] TAG_READY = 9'h1FF;

  // per-cycle commands broadcast to every slot cell
  typedef struct packed {
    logic ins;        // insert into lowest vacant slot
    logic rem;        // free lowest occupied slot matching key
    logic load;       // restart scan token at slot 0
    logic adv;        // move scan token one slot up
    logic clr_taken;  // clear per-query taken marks
  } cell_ctl_t;

  // what the slot holding the scan token shows; zero elsewhere
  typedef struct packed {
    logic                    elig;
    logic [ID_W-1:0]         id;
    logic signed [TAG_W-1:0] t1;
    logic signed [TAG_W-1:0] t2;
  } cell_rd_t;

endpackage

// ===== hw/rtl/sqofs_in_if.sv =====
// Input channel of the scheduling queue: valid/ready plus command fields.
// Depends on sqofs_pkg.
`timescale 1ns / 1ps
interface sqofs_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [sqofs_pkg::CMD_W-1:0]                command;
  logic [sqofs_pkg::ID_W-1:0]                 ins_id;
  logic signed [sqofs_pkg::TAG_W-1:0]         src1_tag;
  logic signed [sqofs_pkg::TAG_W-1:0]         src2_tag;

  modport source(output valid, command, ins_id, src1_tag, src2_tag, input ready);
  modport sink(input valid, command, ins_id, src1_tag, src2_tag, output ready);
endinterface

// ===== hw/rtl/sqofs_out_if.sv =====
// Result channel of the scheduling queue: valid/ready plus result fields.
// Depends on sqofs_pkg.
`timescale 1ns / 1ps
interface sqofs_out_if;
  logic                                valid;
  logic                                ready;
  logic [sqofs_pkg::STS_W-1:0]         status;
  logic                                cand_valid;
  logic [sqofs_pkg::ID_W-1:0]          cand_id;
  logic signed [sqofs_pkg::TAG_W-1:0]  cand_tag1;
  logic signed [sqofs_pkg::TAG_W-1:0]  cand_tag2;
  logic                                last;
  logic [sqofs_pkg::OCC_W-1:0]         occupancy;
  logic                                is_empty;
  logic                                is_full;

  modport source(output valid, status, cand_valid, cand_id, cand_tag1, cand_tag2,
                 last, occupancy, is_empty, is_full, input ready);
  modport sink(input valid, status, cand_valid, cand_id, cand_tag1, cand_tag2,
               last, occupancy, is_empty, is_full, output ready);
endinterface

// ===== hw/rtl/sqofs_cell.sv =====
// One queue slot: occupied bit, ID, two tags, taken mark and scan token.
// Depends on sqofs_pkg. Chained by sqofs top level.
`timescale 1ns / 1ps
module sqofs_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sqofs_pkg::cell_ctl_t               ctl,
  input  logic                               take,
  input  logic [sqofs_pkg::ID_W-1:0]         wr_id,
  input  logic signed [sqofs_pkg::TAG_W-1:0] wr_t1,
  input  logic signed [sqofs_pkg::TAG_W-1:0] wr_t2,
  input  logic                               vac_in,
  input  logic                               hit_in,
  input  logic                               tok_in,
  output logic                               vac_out,
  output logic                               hit_out,
  output logic                               tok_out,
  output sqofs_pkg::cell_rd_t                rd
);

  logic                               occ_r, taken_r, tok_r;
  logic [sqofs_pkg::ID_W-1:0]         id_r;
  logic signed [sqofs_pkg::TAG_W-1:0] t1_r, t2_r;
  logic                               match, do_ins, do_rem, ready;

  assign match   = occ_r && (id_r == wr_id);
  assign vac_out = vac_in | ~occ_r;
  assign hit_out = hit_in | match;
  assign tok_out = tok_r;
  assign do_ins  = ctl.ins && !vac_in && !occ_r;
  assign do_rem  = ctl.rem && !hit_in && match;
  assign ready   = occ_r && (t1_r == sqofs_pkg::TAG_READY) &&
                   (t2_r == sqofs_pkg::TAG_READY);

  always_comb begin
    rd      = '0;
    rd.elig = tok_r && ready && !taken_r;
    if (tok_r) begin
      rd.id = id_r;
      rd.t1 = t1_r;
      rd.t2 = t2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      taken_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      if (do_ins) occ_r <= 1'b1;
      else if (do_rem) occ_r <= 1'b0;
      if (ctl.clr_taken) taken_r <= 1'b0;
      else if (take) taken_r <= 1'b1;
      if (ctl.load) tok_r <= FIRST;
      else if (ctl.adv) tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      id_r <= wr_id;
      t1_r <= wr_t1;
      t2_r <= wr_t2;
    end else if (do_rem) begin
      id_r <= '0;
      t1_r <= '0;
      t2_r <= '0;
    end
  end

endmodule

// ===== hw/rtl/scheduler_queue_oldest_first_select_top.sv =====
// Scheduling queue with oldest-first issue select, built as a chain of slot cells.
// Insert/remove/unused: one item per cycle while results are taken.
// Query: a pass counts ready slots (none ready: one empty result), then a slot-order scan
// emits each of them or, when more are ready than the issue width, per candidate a full
// scan finds the oldest untaken slot and an emit step follows. Results wait in one output register.
// Sync active-low reset empties the queue and sets issue_width to 1.
`timescale 1ns / 1ps
module scheduler_queue_oldest_first_select_top #(
  parameter int ENTRIES   = 16,
  parameter int MAX_ISSUE = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sqofs_in_if.sink                       in_ch,
  sqofs_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [sqofs_pkg::IW_W-1:0]     cfg_data
);

  localparam int IXW = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int KW  = (CW > sqofs_pkg::IW_W) ? CW : sqofs_pkg::IW_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CNT  = 3'd1;  // count ready slots
  localparam logic [2:0] S_SLOT = 3'd2;  // emit ready slots in slot order
  localparam logic [2:0] S_MIN  = 3'd3;  // scan for oldest untaken
  localparam logic [2:0] S_EMIT = 3'd4;  // emit that one

  // ---- slot chain ----
  sqofs_pkg::cell_ctl_t ctl;
  logic [ENTRIES-1:0]   take_vec;
  logic [ENTRIES:0]     vac, hit, tok;
  sqofs_pkg::cell_rd_t  rd_cell [ENTRIES];
  sqofs_pkg::cell_rd_t  rd;

  assign vac[0] = 1'b0;
  assign hit[0] = 1'b0;
  assign tok[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sqofs_cell #(.FIRST(i == 0)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .take   (take_vec[i]),
      .wr_id  (in_ch.ins_id),
      .wr_t1  (in_ch.src1_tag),
      .wr_t2  (in_ch.src2_tag),
      .vac_in (vac[i]),
      .hit_in (hit[i]),
      .tok_in (tok[i]),
      .vac_out(vac[i+1]),
      .hit_out(hit[i+1]),
      .tok_out(tok[i+1]),
      .rd     (rd_cell[i])
    );
  end

  // only the token holder drives nonzero, so OR picks it
  always_comb begin
    rd = '0;
    for (int i = 0; i < ENTRIES; i++) rd = rd | rd_cell[i];
  end

  // ---- registers ----
  logic [2:0]                          st_r, st_nxt;
  logic [IXW-1:0]                      idx_r, idx_nxt;
  logic [CW-1:0]                       cnt_r, cnt_nxt;      // occupied slots
  logic [CW-1:0]                       rcnt_r, rcnt_nxt;    // ready count in scan
  logic [CW-1:0]                       n_r, n_nxt;
  logic [CW-1:0]                       emitted_r, emitted_nxt;
  logic [sqofs_pkg::IW_W-1:0]          round_r, round_nxt;
  logic [sqofs_pkg::IW_W-1:0]          iw_r;
  logic                                best_v_r, best_v_nxt;
  logic [IXW-1:0]                      best_ix_r, best_ix_nxt;
  logic [sqofs_pkg::ID_W-1:0]          best_id_r, best_id_nxt;
  logic signed [sqofs_pkg::TAG_W-1:0]  best_t1_r, best_t1_nxt, best_t2_r, best_t2_nxt;

  logic                                out_v_r;
  logic [sqofs_pkg::STS_W-1:0]         o_sts_r, o_sts_nxt;
  logic                                o_cv_r, o_cv_nxt, o_last_r, o_last_nxt;
  logic [sqofs_pkg::ID_W-1:0]          o_id_r, o_id_nxt;
  logic signed [sqofs_pkg::TAG_W-1:0]  o_t1_r, o_t1_nxt, o_t2_r, o_t2_nxt;

  logic                                ofree, emit, in_acc, last_slot;
  logic [sqofs_pkg::IW_W-1:0]          weff;
  logic [CW-1:0]                       n_now;

  assign ofree     = !out_v_r || out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE) && ofree;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign last_slot = (idx_r == IXW'(ENTRIES - 1));
  assign n_now     = rcnt_r + CW'(rd.elig);

  // zero acts as 1, above MAX_ISSUE clamps
  always_comb begin
    if (iw_r == '0) weff = sqofs_pkg::IW_W'(1);
    else if (iw_r > sqofs_pkg::IW_W'(MAX_ISSUE)) weff = sqofs_pkg::IW_W'(MAX_ISSUE);
    else weff = iw_r;
  end

  always_comb begin
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    rcnt_nxt    = rcnt_r;
    n_nxt       = n_r;
    emitted_nxt = emitted_r;
    round_nxt   = round_r;
    best_v_nxt  = best_v_r;
    best_ix_nxt = best_ix_r;
    best_id_nxt = best_id_r;
    best_t1_nxt = best_t1_r;
    best_t2_nxt = best_t2_r;
    ctl         = '0;
    take_vec    = '0;
    emit        = 1'b0;
    o_sts_nxt   = sqofs_pkg::STS_OK;
    o_cv_nxt    = 1'b0;
    o_id_nxt    = '0;
    o_t1_nxt    = '0;
    o_t2_nxt    = '0;
    o_last_nxt  = 1'b1;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.command)
            sqofs_pkg::CMD_INSERT: begin
              ctl.ins = 1'b1;
              emit    = 1'b1;
              if (vac[ENTRIES]) cnt_nxt = cnt_r + CW'(1);
              else o_sts_nxt = sqofs_pkg::STS_FULL;
            end
            sqofs_pkg::CMD_REMOVE: begin
              ctl.rem = 1'b1;
              emit    = 1'b1;
              if (hit[ENTRIES]) cnt_nxt = cnt_r - CW'(1);
              else o_sts_nxt = sqofs_pkg::STS_NOT_FOUND;
            end
            sqofs_pkg::CMD_QUERY: begin
              ctl.load      = 1'b1;
              ctl.clr_taken = 1'b1;
              idx_nxt       = '0;
              rcnt_nxt      = '0;
              st_nxt        = S_CNT;
            end
            default: emit = 1'b1;  // unused command: plain ok result
          endcase
        end
      end
      S_CNT: begin
        if (!last_slot) begin
          rcnt_nxt = n_now;
          ctl.adv  = 1'b1;
          idx_nxt  = idx_r + IXW'(1);
        end else if (n_now == '0) begin
          if (ofree) begin
            emit   = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          n_nxt    = n_now;
          ctl.load = 1'b1;
          idx_nxt  = '0;
          if (KW'(n_now) <= KW'(weff)) begin
            emitted_nxt = '0;
            st_nxt      = S_SLOT;
          end else begin
            best_v_nxt = 1'b0;
            round_nxt  = '0;
            st_nxt     = S_MIN;
          end
        end
      end
      S_SLOT: begin
        if (!rd.elig || ofree) begin
          if (rd.elig) begin
            emit        = 1'b1;
            o_cv_nxt    = 1'b1;
            o_id_nxt    = rd.id;
            o_t1_nxt    = rd.t1;
            o_t2_nxt    = rd.t2;
            o_last_nxt  = (emitted_r + CW'(1)) == n_r;
            emitted_nxt = emitted_r + CW'(1);
            if (o_last_nxt) st_nxt = S_IDLE;
          end
          ctl.adv = 1'b1;
          idx_nxt = idx_r + IXW'(1);
        end
      end
      S_MIN: begin
        // strict less keeps the lower slot on equal IDs
        if (rd.elig && (!best_v_r || rd.id < best_id_r)) begin
          best_v_nxt  = 1'b1;
          best_ix_nxt = idx_r;
          best_id_nxt = rd.id;
          best_t1_nxt = rd.t1;
          best_t2_nxt = rd.t2;
        end
        ctl.adv = 1'b1;
        if (last_slot) st_nxt = S_EMIT;
        else idx_nxt = idx_r + IXW'(1);
      end
      S_EMIT: begin
        if (ofree) begin
          emit       = 1'b1;
          o_cv_nxt   = 1'b1;
          o_id_nxt   = best_id_r;
          o_t1_nxt   = best_t1_r;
          o_t2_nxt   = best_t2_r;
          o_last_nxt = (round_r + sqofs_pkg::IW_W'(1)) == weff;
          take_vec   = ENTRIES'(1) << best_ix_r;
          if (o_last_nxt) begin
            st_nxt = S_IDLE;
          end else begin
            ctl.load   = 1'b1;
            idx_nxt    = '0;
            best_v_nxt = 1'b0;
            round_nxt  = round_r + sqofs_pkg::IW_W'(1);
            st_nxt     = S_MIN;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= '0;
      iw_r    <= sqofs_pkg::IW_W'(1);
      out_v_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) iw_r <= cfg_data;
      if (emit) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rcnt_r    <= rcnt_nxt;
    n_r       <= n_nxt;
    emitted_r <= emitted_nxt;
    round_r   <= round_nxt;
    best_v_r  <= best_v_nxt;
    best_ix_r <= best_ix_nxt;
    best_id_r <= best_id_nxt;
    best_t1_r <= best_t1_nxt;
    best_t2_r <= best_t2_nxt;
    if (emit) begin
      o_sts_r  <= o_sts_nxt;
      o_cv_r   <= o_cv_nxt;
      o_id_r   <= o_id_nxt;
      o_t1_r   <= o_t1_nxt;
      o_t2_r   <= o_t2_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  // occupancy only changes on insert/remove, whose result is loaded the same edge
  assign out_ch.valid      = out_v_r;
  assign out_ch.status     = o_sts_r;
  assign out_ch.cand_valid = o_cv_r;
  assign out_ch.cand_id    = o_id_r;
  assign out_ch.cand_tag1  = o_t1_r;
  assign out_ch.cand_tag2  = o_t2_r;
  assign out_ch.last       = o_last_r;
  assign out_ch.occupancy  = sqofs_pkg::OCC_W'(cnt_r);
  assign out_ch.is_empty   = (cnt_r == '0);
  assign out_ch.is_full    = (cnt_r == CW'(ENTRIES));

endmodule

// ===== test/tb_scheduler_queue_oldest_first_select_top.sv =====
// Testbench for the oldest-first scheduling queue: random and directed commands
// checked item by item against a behavioral predictor in a scoreboard class.
// Depends on sqofs_pkg, sqofs_in_if, sqofs_out_if and the top level.
`timescale 1ns / 1ps
module tb_scheduler_queue_oldest_first_select_top;

  localparam int SLOTS = 16;
  localparam int WIDTH_CAP = 8;

  typedef struct packed {
    logic [sqofs_pkg::STS_W-1:0]        status;
    logic                               cand_valid;
    logic [sqofs_pkg::ID_W-1:0]         cand_id;
    logic signed [sqofs_pkg::TAG_W-1:0] cand_tag1;
    logic signed [sqofs_pkg::TAG_W-1:0] cand_tag2;
    logic                               last;
    logic [sqofs_pkg::OCC_W-1:0]        occupancy;
    logic                               is_empty;
    logic                               is_full;
  } sched_res_t;

  // Shadow copy of the queue plus the list of results it still owes.
  class sched_scoreboard;
    bit                         occ[SLOTS];
    bit [sqofs_pkg::ID_W-1:0]   sid[SLOTS];
    bit [sqofs_pkg::TAG_W-1:0]  st1[SLOTS];
    bit [sqofs_pkg::TAG_W-1:0]  st2[SLOTS];
    int                         count;
    bit [sqofs_pkg::IW_W-1:0]   width_reg;
    sched_res_t                 pending[$];
    int                         mismatches;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        occ[i] = 0; sid[i] = 0; st1[i] = 0; st2[i] = 0;
      end
      count = 0;
      width_reg = 1;
      pending.delete();
      mismatches = 0;
    endfunction

    function void push(logic [sqofs_pkg::STS_W-1:0] sts, int s, bit valid, bit lst);
      sched_res_t r;
      r.status = sts;
      r.cand_valid = valid;
      r.cand_id = valid ? sid[s] : '0;
      r.cand_tag1 = valid ? st1[s] : '0;
      r.cand_tag2 = valid ? st2[s] : '0;
      r.last = lst;
      r.occupancy = count[sqofs_pkg::OCC_W-1:0];
      r.is_empty = (count == 0);
      r.is_full = (count == SLOTS);
      pending = {pending, r};
    endfunction

    function void note_input(logic [sqofs_pkg::CMD_W-1:0] cmd,
                             logic [sqofs_pkg::ID_W-1:0] id,
                             logic [sqofs_pkg::TAG_W-1:0] t1,
                             logic [sqofs_pkg::TAG_W-1:0] t2);
      int s;
      int w;
      int rdy[$];
      bit taken[SLOTS];
      int best;
      s = SLOTS;
      if (cmd == sqofs_pkg::CMD_INSERT) begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!occ[i]) s = i;
        if (s == SLOTS) push(sqofs_pkg::STS_FULL, 0, 0, 1);
        else begin
          occ[s] = 1; sid[s] = id; st1[s] = t1; st2[s] = t2; count++;
          push(sqofs_pkg::STS_OK, 0, 0, 1);
        end
      end else if (cmd == sqofs_pkg::CMD_REMOVE) begin
        for (int i = SLOTS - 1; i >= 0; i--) if (occ[i] && sid[i] == id) s = i;
        if (s == SLOTS) push(sqofs_pkg::STS_NOT_FOUND, 0, 0, 1);
        else begin
          occ[s] = 0; sid[s] = 0; st1[s] = 0; st2[s] = 0;
          if (count > 0) count--;
          push(sqofs_pkg::STS_OK, 0, 0, 1);
        end
      end else if (cmd == sqofs_pkg::CMD_QUERY) begin
        w = width_reg;
        if (w == 0) w = 1;
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        for (int i = 0; i < SLOTS; i++) begin
          taken[i] = 0;
          if (occ[i] && st1[i] == sqofs_pkg::TAG_READY && st2[i] == sqofs_pkg::TAG_READY)
            rdy = {rdy, i};
        end
        if (rdy.size() == 0) push(sqofs_pkg::STS_OK, 0, 0, 1);
        else if (rdy.size() <= w) begin
          for (int k = 0; k < rdy.size(); k++)
            push(sqofs_pkg::STS_OK, rdy[k], 1, k == rdy.size() - 1);
        end else begin
          // oldest first; ties go to the lower slot
          for (int k = 0; k < w; k++) begin
            best = -1;
            for (int j = 0; j < rdy.size(); j++)
              if (!taken[j] && (best < 0 || sid[rdy[j]] < sid[rdy[best]])) best = j;
            taken[best] = 1;
            push(sqofs_pkg::STS_OK, rdy[best], 1, k == w - 1);
          end
        end
      end else push(sqofs_pkg::STS_OK, 0, 0, 1);
    endfunction

    function void check_result(sched_res_t got);
      sched_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sqofs_pkg::IW_W-1:0] cfg_data;

  sqofs_in_if  in_ch();
  sqofs_out_if out_ch();

  scheduler_queue_oldest_first_select_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  sched_scoreboard sb;
  int send_idle_pct;   // chance in 100 that the sender skips a cycle
  int recv_stall_pct;  // chance in 100 that the receiver holds off

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Overall time limit: far above the slowest legal run.
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random back-pressure, check every accepted result.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.status, out_ch.cand_valid, out_ch.cand_id,
                          out_ch.cand_tag1, out_ch.cand_tag2, out_ch.last,
                          out_ch.occupancy, out_ch.is_empty, out_ch.is_full});
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Present one item; keep valid up until accepted, then note it for prediction.
  task automatic send_item(logic [sqofs_pkg::CMD_W-1:0] cmd,
                           logic [sqofs_pkg::ID_W-1:0] id,
                           logic [sqofs_pkg::TAG_W-1:0] t1,
                           logic [sqofs_pkg::TAG_W-1:0] t2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.ins_id <= id;
    in_ch.src1_tag <= t1;
    in_ch.src2_tag <= t2;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, id, t1, t2);
  endtask

  // Drop valid, wait until every expected result has come, plus a settle time.
  task automatic drain();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_width(logic [sqofs_pkg::IW_W-1:0] w);
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.width_reg = w;
    @(posedge clk);
  endtask

  // Tag: mostly ready so queries find candidates, otherwise any value.
  function automatic logic [sqofs_pkg::TAG_W-1:0] rand_tag();
    if ($urandom_range(99) < 70) return sqofs_pkg::TAG_READY;
    return sqofs_pkg::TAG_W'($urandom_range(511));
  endfunction

  function automatic logic [sqofs_pkg::TAG_W-1:0] any_tag();
    return sqofs_pkg::TAG_W'($urandom_range(511));
  endfunction

  // Random command mix; remove IDs mostly hit something in the queue.
  task automatic random_items(int n);
    logic [sqofs_pkg::ID_W-1:0] id;
    int r, s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      id = ($urandom_range(3) == 0) ? sqofs_pkg::ID_W'($urandom_range(65535))
                                    : sqofs_pkg::ID_W'($urandom_range(40));
      if (r < 45) send_item(sqofs_pkg::CMD_INSERT, id, rand_tag(), rand_tag());
      else if (r < 70) begin
        s = $urandom_range(SLOTS - 1);
        if (sb.occ[s] && $urandom_range(3) != 0) id = sb.sid[s];
        send_item(sqofs_pkg::CMD_REMOVE, id, any_tag(), any_tag());
      end else if (r < 97) send_item(sqofs_pkg::CMD_QUERY, id, any_tag(), any_tag());
      else send_item(sqofs_pkg::CMD_UNUSED, id, any_tag(), any_tag());
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.command = sqofs_pkg::CMD_INSERT;
    in_ch.ins_id = '0;
    in_ch.src1_tag = '0;
    in_ch.src2_tag = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty query and remove at reset width, then fill past full
    // with extreme IDs and tags, including a duplicate ID.
    send_item(sqofs_pkg::CMD_QUERY, 16'd0, '0, '0);
    send_item(sqofs_pkg::CMD_REMOVE, 16'hFFFF, '0, '0);
    send_item(sqofs_pkg::CMD_INSERT, 16'hFFFF, sqofs_pkg::TAG_READY, sqofs_pkg::TAG_READY);
    send_item(sqofs_pkg::CMD_INSERT, 16'd0, sqofs_pkg::TAG_READY, sqofs_pkg::TAG_READY);
    send_item(sqofs_pkg::CMD_INSERT, 16'd0, sqofs_pkg::TAG_READY, sqofs_pkg::TAG_READY);
    send_item(sqofs_pkg::CMD_INSERT, 16'h5555, 9'h0FF, sqofs_pkg::TAG_READY);
    send_item(sqofs_pkg::CMD_INSERT, 16'hAAAA, sqofs_pkg::TAG_READY, 9'h100);
    send_item(sqofs_pkg::CMD_QUERY, 16'd0, '0, '0);
    drain();
    write_width(4'd0);   // zero acts as one
    send_item(sqofs_pkg::CMD_QUERY, 16'd0, '0, '0);
    drain();
    write_width(4'd15);  // clamps to the cap
    for (int i = 0; i < 12; i++)
      send_item(sqofs_pkg::CMD_INSERT, sqofs_pkg::ID_W'(100 - i),
                sqofs_pkg::TAG_READY, sqofs_pkg::TAG_READY);
    // full: rejected
    send_item(sqofs_pkg::CMD_INSERT, 16'd7, sqofs_pkg::TAG_READY, sqofs_pkg::TAG_READY);
    send_item(sqofs_pkg::CMD_QUERY, 16'd0, '0, '0);
    send_item(sqofs_pkg::CMD_UNUSED, 16'hFFFF, 9'h1FF, 9'h1FF);
    send_item(sqofs_pkg::CMD_REMOVE, 16'd0, '0, '0);
    send_item(sqofs_pkg::CMD_QUERY, 16'd0, '0, '0);
    drain();

    // Random phases over idle patterns and widths.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_width((ph == 0) ? 4'd8 : (ph == 7) ? 4'd1
                                   : sqofs_pkg::IW_W'($urandom_range(15)));
      random_items(54);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/sqofs_pkg.sv
hw/rtl/sqofs_in_if.sv
hw/rtl/sqofs_out_if.sv
hw/rtl/sqofs_cell.sv
hw/rtl/scheduler_queue_oldest_first_select_top.sv
test/tb_scheduler_queue_oldest_first_select_top.sv
